// ----- rtl/cs_pkg.sv -----
package cs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4
    } t_scan_mode;

    // One kept character or one line end.
    typedef struct packed {
        logic [7:0] out_char;
        logic       out_line_end;
    } t_result;

    // What one input word asks of the emitter: one result, or two when two is set.
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_cmd;

endpackage

// ----- rtl/cs_if.sv -----
interface cs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       line_break;

    modport source (output valid, output symbol, output line_break, input ready);
    modport sink   (input valid, input symbol, input line_break, output ready);
endinterface

interface cs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_line_end;
    logic       last;

    modport source (output valid, output out_char, output out_line_end, output last,
                    input ready);
    modport sink   (input valid, input out_char, input out_line_end, input last,
                    output ready);
endinterface

// ----- rtl/cs_front.sv -----
module cs_front
    import cs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    cs_in_if.sink  i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    t_scan_mode r_mode, n_mode;
    logic       r_lht, n_lht;
    logic       has;
    logic       accept;
    logic [7:0] ch;
    logic       brk;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign ch         = i_in.symbol;
    assign brk        = i_in.line_break;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_lht  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_lht  <= n_lht;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_lht  = r_lht;
        has    = 1'b0;
        o_cmd  = '0;
        case (r_mode)
            MODE_SLASH: begin
                if (!brk && ch == CH_SLASH) begin
                    n_mode = MODE_LINE;
                end else if (!brk && ch == CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end else begin
                    // The held slash goes out first, then the word itself as a character or a line end.
                    has                   = 1'b1;
                    o_cmd.two             = 1'b1;
                    o_cmd.r0.out_char     = CH_SLASH;
                    n_mode                = MODE_NORMAL;
                    if (brk) begin
                        o_cmd.r1.out_line_end = 1'b1;
                        n_lht                 = 1'b0;
                    end else begin
                        o_cmd.r1.out_char = ch;
                        n_lht             = 1'b1;
                    end
                end
            end
            MODE_LINE: begin
                if (brk) begin
                    n_mode = MODE_NORMAL;
                    if (r_lht) begin
                        has                   = 1'b1;
                        o_cmd.r0.out_line_end = 1'b1;
                        n_lht                 = 1'b0;
                    end
                end
            end
            MODE_BLOCK: begin
                if (!brk && ch == CH_STAR) begin
                    n_mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                if (brk) begin
                    n_mode = MODE_BLOCK;
                end else if (ch == CH_SLASH) begin
                    n_mode = MODE_NORMAL;
                end else if (ch != CH_STAR) begin
                    n_mode = MODE_BLOCK;
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
                if (brk) begin
                    if (r_lht) begin
                        has                   = 1'b1;
                        o_cmd.r0.out_line_end = 1'b1;
                        n_lht                 = 1'b0;
                    end
                end else if (ch == CH_SLASH) begin
                    n_mode = MODE_SLASH;
                end else begin
                    has               = 1'b1;
                    o_cmd.r0.out_char = ch;
                    n_lht             = 1'b1;
                end
            end
        endcase
    end

    assign o_push = accept && has;

endmodule

// ----- rtl/cs_queue.sv -----
module cs_queue
    import cs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/cs_back.sv -----
module cs_back
    import cs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  logic     i_empty,
    output logic     o_pop,
    cs_out_if.source o_out
);

    logic    r_valid;
    logic    r_second;
    t_result r_res;
    logic    r_last;
    logic    load;
    t_result sel;
    logic    sel_last;

    assign load = !i_empty && (!r_valid || o_out.ready);

    always_comb begin
        if (i_cmd.two && !r_second) begin
            sel      = i_cmd.r0;
            sel_last = 1'b0;
        end else if (i_cmd.two) begin
            sel      = i_cmd.r1;
            sel_last = 1'b1;
        end else begin
            sel      = i_cmd.r0;
            sel_last = 1'b1;
        end
    end

    assign o_pop = load && sel_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_second <= !sel_last;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= sel;
            r_last <= sel_last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_char     = r_res.out_char;
    assign o_out.out_line_end = r_res.out_line_end;
    assign o_out.last         = r_last;

endmodule

// ----- rtl/comment_stripper_core.sv -----
// Channel | Dir | Payload                          | Handshake
// i_in    | in  | symbol[7:0], line_break          | valid / ready
// o_out   | out | out_char[7:0], out_line_end, last | valid / ready
//
// One input word is accepted per cycle while the command queue has room.
// Each word yields zero, one or two result words; the emitter sends one
// result word per cycle while o_out.ready allows, so a word that yields
// two is sent as two result words in turn. An accepted word's command is
// written into the queue first, then loaded into the output register.
// Reset (i_rst_n low at a clock edge) returns the scanner to normal text
// and empties the queue and the output register.
// Either side may stall freely: the queue decouples scanner from emitter.
module comment_stripper_core
    import cs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cs_in_if.sink    i_in,
    cs_out_if.source o_out
);

    // Scanner side: classifies each word and decides what must be emitted.
    logic push;
    t_cmd push_cmd;
    logic full;

    // Emitter side: pulls commands and drives the output register.
    logic pop;
    t_cmd head_cmd;
    logic empty;

    cs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // The queue holds whole commands, so a two-result word never splits.
    cs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    cs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- dv/tb_comment_stripper_core.sv -----
`timescale 1ns / 100ps

module tb_comment_stripper_core;
    import cs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD = 150;

    // One source word as it is offered to the block.
    typedef struct packed {
        logic [7:0] sym;
        logic       brk;
    } t_src_word;

    // One result word as the block should send it.
    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
        logic       last;
    } t_kept_word;

    logic clk;
    logic rst_n;

    cs_in_if  in_ch();
    cs_out_if out_ch();

    comment_stripper_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_src_word  src_words[$];
    t_kept_word kept_words[$];
    t_kept_word batch[$];

    // Our own copy of the scanner state.
    t_scan_mode scan_state;
    logic       line_open;

    int  fail_count;
    int  words_accepted;
    int  words_checked;
    int  cycle_count;
    bit  in_fire;
    int  send_gap;
    int  recv_gap;
    int  hold_cycles;
    bit  long_hold_done;

    // ------------------------------------------------------------------
    // Stripping predictor.
    // ------------------------------------------------------------------

    function automatic void push_kept(logic [7:0] ch, logic line_end);
        t_kept_word w;
        w = '{ch, line_end, 1'b0};
        batch.insert(batch.size(), w);
    endfunction

    // A line end goes out only when the output line already holds text.
    function automatic void close_line();
        if (line_open) begin
            push_kept(8'h00, 1'b1);
            line_open = 1'b0;
        end
    endfunction

    function automatic void plain_word(logic [7:0] sym, logic brk);
        if (brk) begin
            close_line();
        end else if (sym == CH_SLASH) begin
            scan_state = MODE_SLASH;
        end else begin
            push_kept(sym, 1'b0);
            line_open = 1'b1;
        end
    endfunction

    function automatic void strip_word(logic [7:0] sym, logic brk);
        batch.delete();
        case (scan_state)
            MODE_SLASH: begin
                if (!brk && sym == CH_SLASH) begin
                    scan_state = MODE_LINE;
                end else if (!brk && sym == CH_STAR) begin
                    scan_state = MODE_BLOCK;
                end else begin
                    // The held slash was plain text after all.
                    push_kept(CH_SLASH, 1'b0);
                    line_open = 1'b1;
                    scan_state = MODE_NORMAL;
                    plain_word(sym, brk);
                end
            end
            MODE_LINE: begin
                if (brk) begin
                    scan_state = MODE_NORMAL;
                    close_line();
                end
            end
            MODE_BLOCK: begin
                if (!brk && sym == CH_STAR) scan_state = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                if (brk) scan_state = MODE_BLOCK;
                else if (sym == CH_SLASH) scan_state = MODE_NORMAL;
                else if (sym != CH_STAR) scan_state = MODE_BLOCK;
            end
            default: begin
                scan_state = MODE_NORMAL;
                plain_word(sym, brk);
            end
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) kept_words.insert(kept_words.size(), batch[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    task automatic add_word(logic [7:0] sym, logic brk);
        t_src_word w;
        w = '{sym, brk};
        src_words.insert(src_words.size(), w);
    endtask

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 99) < 80) return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly back to back, sometimes a short gap, now and then a long one.
    // Between 700 and 900 accepted words no gap is drawn for either side.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (words_accepted >= 700 && words_accepted < 900) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random source text built mostly from well-formed pieces: plain runs,
    // line breaks, line comments, block comments with stars, slashes and
    // breaks inside, and lone slashes. The rest is raw noise. Every word
    // added counts toward the target, comment words included.
    task automatic add_random_text(int target);
        int base;
        int r;
        int len;
        base = src_words.size();
        while (src_words.size() - base < target) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                len = $urandom_range(1, 8);
                repeat (len) add_word(text_byte(), 1'b0);
            end else if (r < 55) begin
                add_word(8'($urandom_range(0, 255)), 1'b1);
            end else if (r < 68) begin
                add_word(CH_SLASH, 1'b0);
                add_word(CH_SLASH, 1'b0);
                repeat ($urandom_range(0, 6)) add_word(8'($urandom_range(0, 255)), 1'b0);
                add_word(8'($urandom_range(0, 255)), 1'b1);
            end else if (r < 85) begin
                add_word(CH_SLASH, 1'b0);
                add_word(CH_STAR, 1'b0);
                repeat ($urandom_range(0, 8)) begin
                    len = $urandom_range(0, 99);
                    if (len < 20) add_word(CH_STAR, 1'b0);
                    else if (len < 30) add_word(CH_SLASH, 1'b0);
                    else if (len < 45) add_word(8'($urandom_range(0, 255)), 1'b1);
                    else add_word(8'($urandom_range(0, 255)), 1'b0);
                end
                repeat ($urandom_range(1, 3)) add_word(CH_STAR, 1'b0);
                add_word(CH_SLASH, 1'b0);
            end else if (r < 92) begin
                add_word(CH_SLASH, 1'b0);
                if ($urandom_range(0, 1) == 0) add_word(text_byte(), 1'b0);
                else add_word(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                add_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // The sender stays quiet until every expected word has come back.
    task automatic wait_drained();
        while (src_words.size() > 0 || kept_words.size() > 0) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, int idx, int want, int got);
        $display("mismatch at result word %0d: %s expected %0h got %0h",
                 idx, what, want, got);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and the stimulus sequence.
    // ------------------------------------------------------------------

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.symbol = 8'h00;
        in_ch.line_break = 1'b0;
        out_ch.ready = 1'b0;
        scan_state = MODE_NORMAL;
        line_open = 1'b0;
        fail_count = 0;
        words_accepted = 0;
        words_checked = 0;
        cycle_count = 0;
        in_fire = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_cycles = 0;
        long_hold_done = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening. Byte extremes, then a line end and an empty
        // line that must vanish.
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h00, 1'b1);
        add_word(8'hFF, 1'b1);
        // A held slash released by a plain character gives two words.
        add_word(CH_SLASH, 1'b0);
        add_word(8'h78, 1'b0);
        // A held slash released by a line break; the break carries a slash
        // byte that has to be ignored.
        add_word(CH_SLASH, 1'b0);
        add_word(CH_SLASH, 1'b1);
        // Text, then a line comment that eats up to the break.
        add_word(8'h63, 1'b0);
        add_word(CH_SLASH, 1'b0);
        add_word(CH_SLASH, 1'b0);
        add_word(8'h71, 1'b0);
        add_word(8'h00, 1'b1);
        // Text, then a block comment opened by slash-star-slash, which does
        // not close it. Breaks inside are dropped, including one right after
        // a star. Repeated stars before the slash close it, and the output
        // line carries on.
        add_word(8'h61, 1'b0);
        add_word(CH_SLASH, 1'b0);
        add_word(CH_STAR, 1'b0);
        add_word(CH_SLASH, 1'b0);
        add_word(CH_STAR, 1'b1);
        add_word(CH_STAR, 1'b0);
        add_word(8'h00, 1'b1);
        add_word(CH_STAR, 1'b0);
        add_word(CH_STAR, 1'b0);
        add_word(CH_SLASH, 1'b0);
        add_word(8'h7A, 1'b0);
        add_word(8'h00, 1'b1);
        add_word(8'h00, 1'b1);
        wait_drained();

        add_random_text(700);
        wait_drained();
        add_random_text(700);

        // A slash as the very last word stays held and yields nothing.
        add_word(CH_SLASH, 1'b0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("tb_comment_stripper_core OK");
        end else begin
            $display("tb_comment_stripper_core NOT OK");
        end
        $finish;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_comment_stripper_core NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side: acceptance is seen at the rising edge, where the word
    // also runs through the predictor. The next word goes out on the
    // falling edge.
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        in_fire = rst_n && in_ch.valid && in_ch.ready;
        if (in_fire) begin
            strip_word(in_ch.symbol, in_ch.line_break);
            void'(src_words.pop_front());
            words_accepted++;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (src_words.size() > 0) begin
                in_ch.valid <= 1'b1;
                in_ch.symbol <= src_words[0].sym;
                in_ch.line_break <= src_words[0].brk;
                send_gap = draw_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side. Once, after 400 accepted words, ready stays low for a
    // long stretch while the sender keeps offering, so the block fills up
    // and has to stall its input.
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (!long_hold_done && words_accepted >= 400) begin
                hold_cycles = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                recv_gap = draw_gap();
            end
        end
    end

    always @(posedge clk) begin
        t_kept_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (kept_words.size() == 0) begin
                report_mismatch("unexpected word, char", words_checked, 0,
                                out_ch.out_char);
            end else begin
                want = kept_words.pop_front();
                if (out_ch.out_char !== want.ch)
                    report_mismatch("out_char", words_checked, want.ch, out_ch.out_char);
                if (out_ch.out_line_end !== want.line_end)
                    report_mismatch("out_line_end", words_checked, want.line_end,
                                    out_ch.out_line_end);
                if (out_ch.last !== want.last)
                    report_mismatch("last", words_checked, want.last, out_ch.last);
            end
            words_checked++;
        end
    end

endmodule

// ----- comment_stripper_core.f -----
rtl/cs_pkg.sv
rtl/cs_if.sv
rtl/cs_front.sv
rtl/cs_queue.sv
rtl/cs_back.sv
rtl/comment_stripper_core.sv
dv/tb_comment_stripper_core.sv
